// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// ===== src/bxd_pkg.sv =====
package bxd_pkg;

   localparam int MAX_WIDTH_DEF  = 4096;
   localparam int MAX_FACTOR_DEF = 16;

   localparam int REG_W       = 13;
   localparam int PIXEL_W     = 8;
   localparam int ROW_W       = 13;
   localparam int ROW_LIMIT   = 4096;
   localparam int CSR_INDEX_W = 4;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [REG_W-1:0] IMAGE_WIDTH_RST   = 13'd640;
   localparam logic [REG_W-1:0] IMAGE_HEIGHT_RST  = 13'd480;
   localparam logic [REG_W-1:0] TARGET_WIDTH_RST  = 13'd80;
   localparam logic [REG_W-1:0] TARGET_HEIGHT_RST = 13'd60;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH   = 4'd0,
      CSR_IMAGE_HEIGHT  = 4'd1,
      CSR_TARGET_WIDTH  = 4'd2,
      CSR_TARGET_HEIGHT = 4'd3
   } csr_index_type;

   typedef logic [PIXEL_W-1:0] pixel_type;

   typedef struct packed {
      logic first;
      logic emit;
      logic row_end;
      logic frame_end;
   } cmd_flags_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef enum logic [2:0] {
      FS_RUN,
      FS_DRAIN,
      FS_FACTOR,
      FS_ROWS,
      FS_COLS,
      FS_RECIP,
      FS_FIRST
   } front_state_type;

   // Width of a block sum: up to factor squared pixels of 255.
   function automatic int sum_width(input int max_factor);
      return $clog2(max_factor * max_factor * 255 + 1);
   endfunction

   function automatic int factor_width(input int max_factor);
      return $clog2(max_factor + 1);
   endfunction

   // Fraction bits of the ceiling reciprocal of the factor.
   function automatic int recip_shift(input int max_factor);
      return sum_width(max_factor) + factor_width(max_factor);
   endfunction

   function automatic int div_width(input int max_width, input int max_factor);
      int w;
      w = recip_shift(max_factor);
      if ($clog2(max_width + 1) > w) w = $clog2(max_width + 1);
      if (REG_W > w) w = REG_W;
      return w;
   endfunction

endpackage

// ===== src/bxd_req_if.sv =====
interface bxd_req_if import bxd_pkg::*; ();
   logic      valid;
   logic      ready;
   pixel_type pixel;

   modport source (output valid, output pixel, input ready);
   modport sink (input valid, input pixel, output ready);
endinterface

// ===== src/bxd_rsp_if.sv =====
interface bxd_rsp_if import bxd_pkg::*; ();
   logic      valid;
   logic      ready;
   pixel_type average;
   logic      last_in_row;
   logic      last_in_frame;

   modport source (output valid, output average, output last_in_row, output last_in_frame,
                   input ready);
   modport sink (input valid, input average, input last_in_row, input last_in_frame,
                 output ready);
endinterface

// ===== src/bxd_divider.sv =====
module bxd_divider import bxd_pkg::*; #(
   parameter int DIV_W = 21
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output div_status_type   status,
   output logic [DIV_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] count_ff;
   logic [DIV_W-1:0] rem_ff;
   logic [DIV_W-1:0] quo_ff;
   logic [DIV_W-1:0] div_ff;

   logic [DIV_W:0]   shifted;
   logic [DIV_W:0]   diff;

   assign shifted = {rem_ff, quo_ff[DIV_W-1]};
   assign diff    = shifted - {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start && !busy_ff) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
         end else if (busy_ff) begin
            count_ff <= count_ff + CNT_W'(1);
            if (count_ff == CNT_W'(DIV_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // One quotient bit a cycle, restoring form.
   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         div_ff <= divisor;
      end else if (busy_ff) begin
         if (!diff[DIV_W]) begin
            rem_ff <= diff[DIV_W-1:0];
            quo_ff <= {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_ff <= shifted[DIV_W-1:0];
            quo_ff <= {quo_ff[DIV_W-2:0], 1'b0};
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

// ===== src/bxd_queue.sv =====
module bxd_queue import bxd_pkg::*; #(
   parameter int DATA_W = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              push_ready,
   input  logic              pop,
   output logic              pop_valid,
   output logic [DATA_W-1:0] pop_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_W-1:0] entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [CNT_W-1:0]  count_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/bxd_front.sv =====
module bxd_front import bxd_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_FACTOR = MAX_FACTOR_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]          csr_index,
   input  logic [REG_W-1:0]                csr_wr_data,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  pixel_type                       req_pixel,
   output logic                            cmd_push,
   input  logic                            cmd_ready,
   output logic [$clog2(MAX_WIDTH)-1:0]    cmd_addr,
   output pixel_type                       cmd_pixel,
   output cmd_flags_type                   cmd_flags,
   input  logic                            drained,
   output logic [recip_shift(MAX_FACTOR):0] recip,
   output logic                            div_start,
   output logic [div_width(MAX_WIDTH, MAX_FACTOR)-1:0] div_dividend,
   output logic [div_width(MAX_WIDTH, MAX_FACTOR)-1:0] div_divisor,
   input  div_status_type                  div_status,
   input  logic [div_width(MAX_WIDTH, MAX_FACTOR)-1:0] div_quotient
);

   localparam int CW     = $clog2(MAX_WIDTH + 1);
   localparam int ADDR_W = $clog2(MAX_WIDTH);
   localparam int FW     = factor_width(MAX_FACTOR);
   localparam int K      = recip_shift(MAX_FACTOR);
   localparam int REC_W  = K + 1;
   localparam int DIV_W  = div_width(MAX_WIDTH, MAX_FACTOR);

   front_state_type state_ff, state_in;

   logic [REG_W-1:0] image_width_ff, image_height_ff, target_width_ff, target_height_ff;

   logic [CW-1:0]    pixel_column_ff, pixel_column_in;
   logic [ROW_W-1:0] pixel_row_ff, pixel_row_in;
   logic [FW-1:0]    sub_column_ff, sub_column_in;
   logic [FW-1:0]    sub_row_ff, sub_row_in;
   logic [CW-1:0]    block_column_ff, block_column_in;
   logic [ROW_W-1:0] block_row_ff, block_row_in;
   logic [FW-1:0]    factor_ff;
   logic [CW-1:0]    blocks_per_row_ff;
   logic [ROW_W-1:0] blocks_per_column_ff;

   logic [CW-1:0]    frame_width_ff;
   logic [ROW_W-1:0] frame_height_ff;
   logic [DIV_W-1:0] num_ff;
   logic [REG_W-1:0] den_ff;
   pixel_type        hold_pixel_ff;
   logic [REC_W-1:0] recip_ff;

   logic [CW-1:0]    width_clamp;
   logic [ROW_W-1:0] height_clamp;
   logic [FW-1:0]    factor_clamp;
   logic             frame_start;
   logic             in_block;
   logic             accept;
   logic             advance;
   logic             latch;

   assign frame_start = (pixel_column_ff == '0) && (pixel_row_ff == '0);
   assign in_block    = (block_column_ff < blocks_per_row_ff) &&
                        (block_row_ff < blocks_per_column_ff);
   assign accept      = req_valid && req_ready;

   always_comb begin
      if (image_width_ff == '0) begin
         width_clamp = CW'(1);
      end else if (int'(image_width_ff) > MAX_WIDTH) begin
         width_clamp = CW'(MAX_WIDTH);
      end else begin
         width_clamp = CW'(image_width_ff);
      end
      if (image_height_ff == '0) begin
         height_clamp = ROW_W'(1);
      end else if (int'(image_height_ff) > ROW_LIMIT) begin
         height_clamp = ROW_W'(ROW_LIMIT);
      end else begin
         height_clamp = ROW_W'(image_height_ff);
      end
      if (div_quotient == '0) begin
         factor_clamp = FW'(1);
      end else if (div_quotient > DIV_W'(MAX_FACTOR)) begin
         factor_clamp = FW'(MAX_FACTOR);
      end else begin
         factor_clamp = FW'(div_quotient);
      end
   end

   // Command for the pixel at the current position.
   assign cmd_addr            = block_column_ff[ADDR_W-1:0];
   assign cmd_pixel           = (state_ff == FS_FIRST) ? hold_pixel_ff : req_pixel;
   assign cmd_flags.first     = (sub_row_ff == '0) && (sub_column_ff == '0);
   assign cmd_flags.emit      = in_block && (sub_row_ff == factor_ff - FW'(1)) &&
                                (sub_column_ff == factor_ff - FW'(1));
   assign cmd_flags.row_end   = (block_column_ff == blocks_per_row_ff - CW'(1));
   assign cmd_flags.frame_end = cmd_flags.row_end &&
                                (block_row_ff == blocks_per_column_ff - ROW_W'(1));
   assign recip               = recip_ff;

   always_comb begin
      sub_column_in   = sub_column_ff + FW'(1);
      block_column_in = block_column_ff;
      pixel_column_in = pixel_column_ff + CW'(1);
      sub_row_in      = sub_row_ff;
      block_row_in    = block_row_ff;
      pixel_row_in    = pixel_row_ff;
      if (sub_column_in >= factor_ff) begin
         sub_column_in   = '0;
         block_column_in = block_column_ff + CW'(1);
      end
      if (pixel_column_in >= frame_width_ff) begin
         pixel_column_in = '0;
         sub_column_in   = '0;
         block_column_in = '0;
         sub_row_in      = sub_row_ff + FW'(1);
         if (sub_row_in >= factor_ff) begin
            sub_row_in   = '0;
            block_row_in = block_row_ff + ROW_W'(1);
         end
         pixel_row_in = pixel_row_ff + ROW_W'(1);
         if (pixel_row_in >= frame_height_ff) begin
            pixel_row_in = '0;
            sub_row_in   = '0;
            block_row_in = '0;
         end
      end
   end

   always_comb begin
      case (state_ff)
         FS_FACTOR: begin
            div_dividend = num_ff;
            div_divisor  = DIV_W'(den_ff);
         end
         FS_ROWS: begin
            div_dividend = DIV_W'(frame_width_ff);
            div_divisor  = DIV_W'(factor_ff);
         end
         FS_COLS: begin
            div_dividend = DIV_W'(frame_height_ff);
            div_divisor  = DIV_W'(factor_ff);
         end
         FS_RECIP: begin
            div_dividend = DIV_W'((64'd1 << K) - 64'd1);
            div_divisor  = DIV_W'(factor_ff);
         end
         default: begin
            div_dividend = num_ff;
            div_divisor  = DIV_W'(den_ff);
         end
      endcase
   end

   // Outputs per state.
   always_comb begin
      req_ready = 1'b0;
      cmd_push  = 1'b0;
      advance   = 1'b0;
      latch     = 1'b0;
      div_start = 1'b0;
      case (state_ff)
         FS_RUN: begin
            req_ready = frame_start || !in_block || cmd_ready;
            cmd_push  = accept && !frame_start && in_block;
            advance   = accept && !frame_start;
            latch     = accept && frame_start;
         end
         FS_FACTOR, FS_ROWS, FS_COLS, FS_RECIP: begin
            div_start = !div_status.busy && !div_status.done;
         end
         FS_FIRST: begin
            cmd_push = in_block && cmd_ready;
            advance  = !in_block || cmd_ready;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FS_RUN: begin
            if (latch) state_in = FS_DRAIN;
         end
         FS_DRAIN: begin
            if (drained) state_in = (den_ff == '0) ? FS_ROWS : FS_FACTOR;
         end
         FS_FACTOR: begin
            if (div_status.done) state_in = FS_ROWS;
         end
         FS_ROWS: begin
            if (div_status.done) state_in = FS_COLS;
         end
         FS_COLS: begin
            if (div_status.done) state_in = FS_RECIP;
         end
         FS_RECIP: begin
            if (div_status.done) state_in = FS_FIRST;
         end
         FS_FIRST: begin
            if (advance) state_in = FS_RUN;
         end
         default: begin
            state_in = FS_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff             <= FS_RUN;
         image_width_ff       <= IMAGE_WIDTH_RST;
         image_height_ff      <= IMAGE_HEIGHT_RST;
         target_width_ff      <= TARGET_WIDTH_RST;
         target_height_ff     <= TARGET_HEIGHT_RST;
         pixel_column_ff      <= '0;
         pixel_row_ff         <= '0;
         sub_column_ff        <= '0;
         sub_row_ff           <= '0;
         block_column_ff      <= '0;
         block_row_ff         <= '0;
         factor_ff            <= '0;
         blocks_per_row_ff    <= '0;
         blocks_per_column_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:   image_width_ff   <= csr_wr_data;
               CSR_IMAGE_HEIGHT:  image_height_ff  <= csr_wr_data;
               CSR_TARGET_WIDTH:  target_width_ff  <= csr_wr_data;
               CSR_TARGET_HEIGHT: target_height_ff <= csr_wr_data;
               default: begin
               end
            endcase
         end
         if (advance) begin
            pixel_column_ff <= pixel_column_in;
            pixel_row_ff    <= pixel_row_in;
            sub_column_ff   <= sub_column_in;
            sub_row_ff      <= sub_row_in;
            block_column_ff <= block_column_in;
            block_row_ff    <= block_row_in;
         end
         // A zero target skips the quotient and takes the largest factor.
         if (state_ff == FS_DRAIN && drained && den_ff == '0) begin
            factor_ff <= FW'(MAX_FACTOR);
         end
         if (state_ff == FS_FACTOR && div_status.done) begin
            factor_ff <= factor_clamp;
         end
         if (state_ff == FS_ROWS && div_status.done) begin
            blocks_per_row_ff <= div_quotient[CW-1:0];
         end
         if (state_ff == FS_COLS && div_status.done) begin
            blocks_per_column_ff <= div_quotient[ROW_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (latch) begin
         frame_width_ff  <= width_clamp;
         frame_height_ff <= height_clamp;
         hold_pixel_ff   <= req_pixel;
         if (target_width_ff < target_height_ff) begin
            num_ff <= DIV_W'(width_clamp);
            den_ff <= target_width_ff;
         end else begin
            num_ff <= DIV_W'(height_clamp);
            den_ff <= target_height_ff;
         end
      end
      // Ceiling reciprocal of the factor.
      if (state_ff == FS_RECIP && div_status.done) begin
         recip_ff <= REC_W'(div_quotient) + REC_W'(1);
      end
   end

endmodule

// ===== src/bxd_back.sv =====
module bxd_back import bxd_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_FACTOR = MAX_FACTOR_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             head_valid,
   output logic                             head_pop,
   input  logic [$clog2(MAX_WIDTH)-1:0]     head_addr,
   input  pixel_type                        head_pixel,
   input  cmd_flags_type                    head_flags,
   input  logic [recip_shift(MAX_FACTOR):0] recip,
   output logic                             idle,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output pixel_type                        rsp_average,
   output logic                             rsp_last_in_row,
   output logic                             rsp_last_in_frame
);

   localparam int ADDR_W = $clog2(MAX_WIDTH);
   localparam int S      = sum_width(MAX_FACTOR);
   localparam int K      = recip_shift(MAX_FACTOR);
   localparam int REC_W  = K + 1;
   localparam int P_W    = S + REC_W;

   logic [S-1:0]      sums_mem [MAX_WIDTH];

   logic              b_valid_ff;
   logic [ADDR_W-1:0] b_addr_ff;
   pixel_type         b_pixel_ff;
   cmd_flags_type     b_flags_ff;
   logic [S-1:0]      rdata_ff;
   logic              fwd_hit_ff;
   logic [S-1:0]      fwd_sum_ff;

   logic              p1_valid_ff;
   logic [P_W-1:0]    p1_ff;
   logic              p1_row_ff, p1_frame_ff;
   logic              p2_valid_ff;
   logic [P_W-1:0]    p2_ff;
   logic              p2_row_ff, p2_frame_ff;
   logic              out_valid_ff;
   pixel_type         out_avg_ff;
   logic              out_row_ff, out_frame_ff;

   logic              out_free, p2_move, p2_free, p1_move, p1_free;
   logic              b_fire, b_load;
   logic [S-1:0]      prior_sum;
   logic [S-1:0]      sum_b;
   logic [S-1:0]      quot1;

   assign out_free = !out_valid_ff || rsp_ready;
   assign p2_move  = p2_valid_ff && out_free;
   assign p2_free  = !p2_valid_ff || p2_move;
   assign p1_move  = p1_valid_ff && p2_free;
   assign p1_free  = !p1_valid_ff || p1_move;
   assign b_fire   = b_valid_ff && (!b_flags_ff.emit || p1_free);
   assign b_load   = head_valid && (!b_valid_ff || b_fire);
   assign head_pop = b_load;
   assign idle     = !b_valid_ff && !p1_valid_ff && !p2_valid_ff;

   // The entry written on the edge this command was read misses the read: forward it.
   assign prior_sum = fwd_hit_ff ? fwd_sum_ff : rdata_ff;
   assign sum_b     = b_flags_ff.first ? S'(b_pixel_ff) : prior_sum + S'(b_pixel_ff);
   assign quot1     = S'(p1_ff >> K);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (b_load) begin
            b_valid_ff <= 1'b1;
         end else if (b_fire) begin
            b_valid_ff <= 1'b0;
         end
         if (b_fire && b_flags_ff.emit) begin
            p1_valid_ff <= 1'b1;
         end else if (p1_move) begin
            p1_valid_ff <= 1'b0;
         end
         if (p1_move) begin
            p2_valid_ff <= 1'b1;
         end else if (p2_move) begin
            p2_valid_ff <= 1'b0;
         end
         if (p2_move) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Line buffer of block sums: read on load, write back on fire.
   always_ff @(posedge clock) begin
      if (b_load) begin
         rdata_ff <= sums_mem[head_addr];
      end
      if (b_fire) begin
         sums_mem[b_addr_ff] <= sum_b;
      end
   end

   always_ff @(posedge clock) begin
      if (b_load) begin
         b_addr_ff  <= head_addr;
         b_pixel_ff <= head_pixel;
         b_flags_ff <= head_flags;
         fwd_hit_ff <= b_fire && (b_addr_ff == head_addr);
         fwd_sum_ff <= sum_b;
      end
      // Divide by the factor twice, each by multiplying with its ceiling reciprocal.
      if (b_fire && b_flags_ff.emit) begin
         p1_ff       <= P_W'(sum_b) * P_W'(recip);
         p1_row_ff   <= b_flags_ff.row_end;
         p1_frame_ff <= b_flags_ff.frame_end;
      end
      if (p1_move) begin
         p2_ff       <= P_W'(quot1) * P_W'(recip);
         p2_row_ff   <= p1_row_ff;
         p2_frame_ff <= p1_frame_ff;
      end
      if (p2_move) begin
         out_avg_ff   <= PIXEL_W'(p2_ff >> K);
         out_row_ff   <= p2_row_ff;
         out_frame_ff <= p2_frame_ff;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_average       = out_avg_ff;
   assign rsp_last_in_row   = out_row_ff;
   assign rsp_last_in_frame = out_frame_ff;

endmodule

// ===== src/box_average_image_downscale.sv =====
// Box-average downscaler for 8-bit grey pixels in raster order. Each f-by-f block gives one
// output pixel, the truncated mean, delivered after the pixel at the block's bottom-right
// corner; partial blocks at the right and bottom edges are dropped. Within a frame one pixel
// is taken per clock while the command queue has room, set by the single read-modify-write
// of the block-sum line buffer per pixel. The first pixel of each frame is taken at once, but
// the next waits while the back end drains (longer while results are held off) and the shared
// serial divider runs four times (factor, blocks per row, blocks per column, reciprocal) on
// DIV_W-bit operands (DIV_W = 21 at the default parameters); a zero target in the chosen
// direction skips the first. After its completing pixel is taken (for a frame's first pixel,
// after the set-up), a result passes the queue, the line-buffer stage, the p1 and p2 multiply
// stages and the output register. Register writes take effect at the next frame start. The
// line buffer needs no clearing after reset.
`include "assert_macros.svh"

module box_average_image_downscale import bxd_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_FACTOR = MAX_FACTOR_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   bxd_req_if.sink                req_chan,
   bxd_rsp_if.source              rsp_chan,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [REG_W-1:0]       csr_wr_data
);

   localparam int ADDR_W  = $clog2(MAX_WIDTH);
   localparam int K       = recip_shift(MAX_FACTOR);
   localparam int DIV_W   = div_width(MAX_WIDTH, MAX_FACTOR);
   localparam int FLAGS_W = $bits(cmd_flags_type);
   localparam int CMD_W   = ADDR_W + PIXEL_W + FLAGS_W;

   logic              q_push;
   logic              q_ready;
   logic              q_valid;
   logic              q_pop;
   logic [CMD_W-1:0]  q_head;
   logic [ADDR_W-1:0] cmd_addr;
   pixel_type         cmd_pixel;
   cmd_flags_type     cmd_flags;
   logic [ADDR_W-1:0] head_addr;
   pixel_type         head_pixel;
   cmd_flags_type     head_flags;
   logic              back_idle;
   logic              drained;
   logic [K:0]        recip;
   logic              div_start;
   logic [DIV_W-1:0]  div_dividend;
   logic [DIV_W-1:0]  div_divisor;
   div_status_type    div_status;
   logic [DIV_W-1:0]  div_quotient;

   assign drained    = !q_valid && back_idle;
   assign head_addr  = q_head[CMD_W-1 -: ADDR_W];
   assign head_pixel = q_head[FLAGS_W +: PIXEL_W];
   assign head_flags = q_head[FLAGS_W-1:0];

   bxd_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_FACTOR (MAX_FACTOR)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wr_data  (csr_wr_data),
      .req_valid    (req_chan.valid),
      .req_ready    (req_chan.ready),
      .req_pixel    (req_chan.pixel),
      .cmd_push     (q_push),
      .cmd_ready    (q_ready),
      .cmd_addr     (cmd_addr),
      .cmd_pixel    (cmd_pixel),
      .cmd_flags    (cmd_flags),
      .drained      (drained),
      .recip        (recip),
      .div_start    (div_start),
      .div_dividend (div_dividend),
      .div_divisor  (div_divisor),
      .div_status   (div_status),
      .div_quotient (div_quotient)
   );

   bxd_divider #(
      .DIV_W (DIV_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .status   (div_status),
      .quotient (div_quotient)
   );

   bxd_queue #(
      .DATA_W (CMD_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  ({cmd_addr, cmd_pixel, cmd_flags}),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_data   (q_head)
   );

   bxd_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_FACTOR (MAX_FACTOR)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (q_valid),
      .head_pop          (q_pop),
      .head_addr         (head_addr),
      .head_pixel        (head_pixel),
      .head_flags        (head_flags),
      .recip             (recip),
      .idle              (back_idle),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_average       (rsp_chan.average),
      .rsp_last_in_row   (rsp_chan.last_in_row),
      .rsp_last_in_frame (rsp_chan.last_in_frame)
   );

   `ASSERT_IMPLIES(a_push_has_room, clock, reset, q_push, q_ready)
   `ASSERT_IMPLIES(a_setup_only_when_drained, clock, reset, div_start, !q_valid && back_idle)
   `ASSERT_NEXT(a_recip_held_while_busy, clock, reset, !back_idle, $stable(recip))

endmodule

// ===== test/bxd_checker.sv =====
`timescale 1ns / 100ps

module bxd_checker import bxd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   bxd_req_if                     req_chan,
   bxd_rsp_if                     rsp_chan,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [REG_W-1:0]       csr_wr_data,
   output int                     fail_count,
   output int                     outstanding
);

   typedef struct packed {
      pixel_type average;
      logic      last_in_row;
      logic      last_in_frame;
   } block_mean_type;

   block_mean_type expected_means[$];

   logic [REG_W-1:0] width_reg, height_reg, tgt_width_reg, tgt_height_reg;

   // frame geometry latched at the first pixel of each frame
   int frame_w, frame_h, factor, blocks_across, blocks_down;
   int col, row, sub_col, sub_row, blk_col, blk_row;
   int block_sum [MAX_WIDTH_DEF];

   function automatic int clamp_extent(input int v, input int limit);
      if (v == 0) return 1;
      return (v > limit) ? limit : v;
   endfunction

   task automatic latch_frame();
      int q;
      frame_w = clamp_extent(width_reg, MAX_WIDTH_DEF);
      frame_h = clamp_extent(height_reg, ROW_LIMIT);
      if (tgt_width_reg < tgt_height_reg)
         q = (tgt_width_reg == 0) ? MAX_FACTOR_DEF : frame_w / tgt_width_reg;
      else
         q = (tgt_height_reg == 0) ? MAX_FACTOR_DEF : frame_h / tgt_height_reg;
      if (q < 1) q = 1;
      if (q > MAX_FACTOR_DEF) q = MAX_FACTOR_DEF;
      factor = q;
      blocks_across = frame_w / q;
      blocks_down = frame_h / q;
   endtask

   task automatic accumulate_pixel(input pixel_type px);
      int             sum;
      logic           row_end;
      block_mean_type mean;
      if (col == 0 && row == 0) latch_frame();
      if (blk_col < blocks_across && blk_row < blocks_down && blk_col < MAX_WIDTH_DEF) begin
         // the top-left pixel of a block restarts its sum
         if (sub_row == 0 && sub_col == 0)
            sum = px;
         else
            sum = block_sum[blk_col] + px;
         block_sum[blk_col] = sum;
         if (sub_row == factor - 1 && sub_col == factor - 1) begin
            row_end = (blk_col == blocks_across - 1);
            mean.average = pixel_type'(sum / (factor * factor));
            mean.last_in_row = row_end;
            mean.last_in_frame = row_end && (blk_row == blocks_down - 1);
            expected_means = {expected_means, mean};
         end
      end
      sub_col++;
      if (sub_col >= factor) begin
         sub_col = 0;
         blk_col++;
      end
      col++;
      if (col >= frame_w) begin
         col = 0;
         sub_col = 0;
         blk_col = 0;
         sub_row++;
         if (sub_row >= factor) begin
            sub_row = 0;
            blk_row++;
         end
         row++;
         if (row >= frame_h) begin
            row = 0;
            sub_row = 0;
            blk_row = 0;
         end
      end
   endtask

   always @(posedge clock) begin : watch
      block_mean_type want;
      if (reset) begin
         width_reg = IMAGE_WIDTH_RST;
         height_reg = IMAGE_HEIGHT_RST;
         tgt_width_reg = TARGET_WIDTH_RST;
         tgt_height_reg = TARGET_HEIGHT_RST;
         frame_w = 0;
         frame_h = 0;
         factor = 0;
         blocks_across = 0;
         blocks_down = 0;
         col = 0;
         row = 0;
         sub_col = 0;
         sub_row = 0;
         blk_col = 0;
         blk_row = 0;
         fail_count = 0;
         expected_means.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:   width_reg = csr_wr_data;
               CSR_IMAGE_HEIGHT:  height_reg = csr_wr_data;
               CSR_TARGET_WIDTH:  tgt_width_reg = csr_wr_data;
               CSR_TARGET_HEIGHT: tgt_height_reg = csr_wr_data;
               default: ;
            endcase
         end
         if (req_chan.valid && req_chan.ready) accumulate_pixel(req_chan.pixel);
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_means.size() == 0) begin
               $error("average: expected none, got %0d", rsp_chan.average);
               fail_count++;
            end else begin
               want = expected_means.pop_front();
               if (rsp_chan.average !== want.average) begin
                  $error("average: expected %0d, got %0d", want.average, rsp_chan.average);
                  fail_count++;
               end
               if (rsp_chan.last_in_row !== want.last_in_row) begin
                  $error("last_in_row: expected %0d, got %0d", want.last_in_row,
                         rsp_chan.last_in_row);
                  fail_count++;
               end
               if (rsp_chan.last_in_frame !== want.last_in_frame) begin
                  $error("last_in_frame: expected %0d, got %0d", want.last_in_frame,
                         rsp_chan.last_in_frame);
                  fail_count++;
               end
            end
         end
      end
      outstanding = expected_means.size();
   end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import bxd_pkg::*;

   localparam int RANDOM_PIXELS   = 850;
   localparam int PRESSURE_PIXELS = 300;
   localparam int SETTLE_CYCLES   = 150;
   localparam int DRAIN_CYCLES    = 50;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int CYCLE_LIMIT     = 1000000;

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [REG_W-1:0]       csr_wr_data;

   bxd_req_if req_chan ();
   bxd_rsp_if rsp_chan ();

   int send_idle_pct;
   int stall_pct;
   int idle_phase;
   bit hold_off;
   bit pressure_arm;
   int pixels_sent;
   int frame_left;
   int fail_count;
   int outstanding;
   int random_start;
   int shadow_regs [4];

   box_average_image_downscale i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   bxd_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("simulation failed");
      $finish;
   end

   always @(negedge clock) begin
      rsp_chan.ready <= !hold_off && ($urandom_range(0, 99) >= stall_pct);
   end

   // hold the result side off long enough for the block to back up into its input
   initial begin
      wait (pressure_arm);
      repeat (200) @(posedge clock);
      hold_off = 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
      hold_off = 1'b0;
   end

   function automatic int frame_pixels();
      int w, h;
      w = shadow_regs[CSR_IMAGE_WIDTH];
      h = shadow_regs[CSR_IMAGE_HEIGHT];
      if (w == 0) w = 1;
      if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
      if (h == 0) h = 1;
      if (h > ROW_LIMIT) h = ROW_LIMIT;
      return w * h;
   endfunction

   function automatic int random_extent();
      return ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 20);
   endfunction

   function automatic int random_target();
      return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 12);
   endfunction

   task automatic next_idling();
      case (idle_phase % 4)
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 71; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 71; end
         default: begin send_idle_pct = 16; stall_pct = 16; end
      endcase
      idle_phase++;
   endtask

   task automatic write_reg(input csr_index_type idx, input int value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= value[REG_W-1:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
      shadow_regs[idx] = value;
   endtask

   task automatic program_frame(input int w, input int h, input int tw, input int th);
      write_reg(CSR_IMAGE_WIDTH, w);
      write_reg(CSR_IMAGE_HEIGHT, h);
      write_reg(CSR_TARGET_WIDTH, tw);
      write_reg(CSR_TARGET_HEIGHT, th);
   endtask

   // a negative level gives random grey levels
   task automatic send_pixels(input int count, input int level);
      for (int n = 0; n < count; n++) begin
         @(negedge clock);
         while ($urandom_range(0, 99) < send_idle_pct) begin
            req_chan.valid <= 1'b0;
            @(negedge clock);
         end
         req_chan.valid <= 1'b1;
         req_chan.pixel <= (level < 0) ? pixel_type'($urandom_range(0, 255)) : pixel_type'(level);
         do @(posedge clock); while (!req_chan.ready);
         if (frame_left == 0) frame_left = frame_pixels();
         frame_left--;
         pixels_sent++;
      end
      @(negedge clock);
      req_chan.valid <= 1'b0;
   endtask

   task automatic finish_frame(input int level);
      send_pixels((frame_left != 0) ? frame_left : frame_pixels(), level);
   endtask

   // wait out the results, then any pixel still in flight or a frame-start computation
   task automatic settle();
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CSR_IMAGE_WIDTH;
      csr_wr_data = '0;
      req_chan.valid = 1'b0;
      req_chan.pixel = '0;
      shadow_regs[CSR_IMAGE_WIDTH] = IMAGE_WIDTH_RST;
      shadow_regs[CSR_IMAGE_HEIGHT] = IMAGE_HEIGHT_RST;
      shadow_regs[CSR_TARGET_WIDTH] = TARGET_WIDTH_RST;
      shadow_regs[CSR_TARGET_HEIGHT] = TARGET_HEIGHT_RST;
      frame_left = 0;
      idle_phase = 0;
      next_idling();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero image size: one-pixel frames, every pixel is a whole frame
      program_frame(0, 0, 1, 1);
      send_pixels(1, 0);
      send_pixels(1, 255);
      send_pixels(1, -1);
      settle();
      next_idling();

      // factor two from the width direction, extreme levels
      program_frame(4, 4, 2, 3);
      finish_frame(255);
      finish_frame(0);
      finish_frame(-1);
      settle();
      next_idling();

      // quotient of zero clamps to one
      program_frame(3, 2, 5, 5);
      finish_frame(-1);
      settle();
      next_idling();

      // factor three but only two columns: no whole block
      program_frame(2, 9, 5, 3);
      finish_frame(-1);
      settle();
      next_idling();

      // zero target picks the largest factor; full-scale sum
      program_frame(16, 16, 0, 1);
      finish_frame(255);
      settle();
      next_idling();

      // quotient above the largest factor, partial block on the right dropped
      program_frame(17, 16, 1, 2);
      finish_frame(-1);
      settle();
      next_idling();

      // change the registers part way through a frame
      program_frame(4, 4, 4, 2);
      send_pixels(6, -1);
      settle();
      program_frame(3, 3, 1, 1);
      finish_frame(-1);
      finish_frame(-1);
      settle();

      random_start = pixels_sent;
      while (pixels_sent - random_start < RANDOM_PIXELS) begin
         next_idling();
         if ($urandom_range(0, 3) == 0) begin
            if ($urandom_range(0, 1)) write_reg(CSR_IMAGE_WIDTH, random_extent());
            if ($urandom_range(0, 1)) write_reg(CSR_IMAGE_HEIGHT, random_extent());
            if ($urandom_range(0, 1)) write_reg(CSR_TARGET_WIDTH, random_target());
            if ($urandom_range(0, 1)) write_reg(CSR_TARGET_HEIGHT, random_target());
         end else begin
            program_frame(random_extent(), random_extent(), random_target(), random_target());
         end
         if ($urandom_range(0, 2) == 0) begin
            send_pixels($urandom_range(1, 150), -1);
         end else begin
            finish_frame(-1);
            finish_frame(-1);
         end
         settle();
      end

      // round off the frame in progress so the last set-up starts a fresh frame
      if (frame_left != 0) begin
         finish_frame(-1);
         settle();
      end

      // oversize width, one row of single-pixel blocks; the long hold-off lands here
      send_idle_pct = 0;
      stall_pct = 0;
      program_frame(8191, 1, 4096, 4097);
      pressure_arm = 1'b1;
      send_pixels(PRESSURE_PIXELS, -1);

      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
